// ===== rtl/core/bet_pkg.sv =====
`default_nettype none

package bet_pkg;

	localparam int unsigned CHAN_IDX_W  = 5;
	localparam int unsigned EDGE_TIME_W = 16;
	localparam int unsigned SAMPLE_W    = 32;
	localparam int unsigned M_TDATA_W   = 24;

	localparam logic EDGE_LEADING  = 1'b0;
	localparam logic EDGE_TRAILING = 1'b1;

	typedef struct packed {
		logic                   last;
		logic                   kind;
		logic [EDGE_TIME_W-1:0] etime;
		logic [CHAN_IDX_W-1:0]  chan;
	} edge_t;

	typedef struct packed {
		logic load;
		logic step;
	} scan_ctl_t;

	typedef struct packed {
		logic hit;
		logic level;
		logic more;
	} scan_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/bet_scan.sv =====
`default_nettype none

// Walks a channel mask one position per cycle while ctl.step is high, lowest channel first.
module bet_scan #(
	parameter int unsigned NUM_CHANNELS = 32,
	parameter int unsigned CHAN_W       = 5
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  bet_pkg::scan_ctl_t      ctl,
	input  wire [NUM_CHANNELS-1:0]  load_mask,
	input  wire [NUM_CHANNELS-1:0]  load_level,
	output bet_pkg::scan_sts_t      sts,
	output logic [CHAN_W-1:0]       chan
);

	logic [NUM_CHANNELS-1:0] rem_q;
	logic [NUM_CHANNELS-1:0] lev_q;
	logic [CHAN_W-1:0]       chan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			chan_q <= '0;
		end else if (ctl.load) begin
			rem_q  <= load_mask;
			chan_q <= '0;
		end else if (ctl.step) begin
			rem_q  <= rem_q >> 1;
			chan_q <= chan_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			lev_q <= load_level;
		end else if (ctl.step) begin
			lev_q <= lev_q >> 1;
		end
	end

	always_comb begin
		sts.hit   = rem_q[0];
		sts.level = lev_q[0];
		sts.more  = |rem_q[NUM_CHANNELS-1:1];
		chan      = chan_q;
	end

endmodule

`default_nettype wire

// ===== rtl/core/bet_out_reg.sv =====
`default_nettype none

// Output holding register; takes a new edge in the same cycle the held one leaves.
module bet_out_reg (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  bet_pkg::edge_t  in_edge,
	output logic            out_valid,
	input  wire             out_ready,
	output bet_pkg::edge_t  out_edge
);

	logic           valid_q;
	bet_pkg::edge_t edge_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_edge  = edge_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			edge_q <= in_edge;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_edge_timestamper_unit.sv =====
`default_nettype none

// Converts a stream of channel-level snapshots into timestamped edge transfers.
// Each input transfer is one time slot; the first slot of a frame (s_tuser high)
// restarts the time at zero and reports a leading edge for every high channel,
// later slots report each channel that changed, and the last slot (s_tlast high)
// also closes every still-high channel with a trailing edge one step later. Edges
// leave in ascending channel order and m_tlast marks the last edge of a slot; a
// slot with no edges produces no transfer. A slot occupies a single shift scanner
// that examines one channel per cycle while no edge waits on the output: a slot is
// accepted, then scanned one channel position at a time up to the highest channel
// with an edge, then on a last slot with any high channel scanned again up to the
// highest high channel; an edge waits while the output register is still full and
// m_tready is low, and no new slot is taken until the scan ends. s_tready is high
// only between slots. The time saturates at 2**TIME_BITS - 1 and is reported in
// 16 bits.
module bitmap_edge_timestamper_unit #(
	parameter int unsigned NUM_CHANNELS = 32,
	parameter int unsigned TIME_BITS    = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire [bet_pkg::SAMPLE_W-1:0]        s_tdata,  // [31:0] sample_word
	input  wire                                s_tuser,  // [0] frame_start
	input  wire                                s_tlast,  // frame_end
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [bet_pkg::M_TDATA_W-1:0]      m_tdata,  // [4:0] channel_index, [20:5] edge_time
	output logic                               m_tuser,  // [0] edge_kind
	output logic                               m_tlast   // run_last
);

	localparam int unsigned CHAN_W = $clog2(NUM_CHANNELS);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN_A = 2'd1;
	localparam logic [1:0] ST_SCAN_B = 2'd2;

	logic [1:0]              state_q;
	logic [NUM_CHANNELS-1:0] prev_q;
	logic [NUM_CHANNELS-1:0] sample_q;
	logic [TIME_BITS-1:0]    time_q;
	logic [TIME_BITS-1:0]    etime_q;
	logic                    use_lev_q;
	logic                    close_q;

	logic [NUM_CHANNELS-1:0] sample;
	logic [TIME_BITS-1:0]    time_next;
	logic                    accept;
	logic                    scanning;
	logic                    advance;
	logic                    to_close;
	logic                    oq_ready;
	logic                    oq_valid;

	bet_pkg::scan_ctl_t      sctl;
	bet_pkg::scan_sts_t      ssts;
	logic [CHAN_W-1:0]       chan;
	logic [NUM_CHANNELS-1:0] load_mask;
	logic [NUM_CHANNELS-1:0] load_level;
	logic [CHAN_W+bet_pkg::CHAN_IDX_W-1:0]   chan_ext;
	logic [TIME_BITS+bet_pkg::EDGE_TIME_W-1:0] time_ext;
	bet_pkg::edge_t          new_edge;
	bet_pkg::edge_t          out_edge;

	assign sample    = s_tdata[NUM_CHANNELS-1:0];
	assign time_next = (&time_q) ? time_q : time_q + 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign scanning  = (state_q != ST_IDLE);
	assign advance   = scanning && (!ssts.hit || oq_ready);
	assign to_close  = advance && !ssts.more && (state_q == ST_SCAN_A) && close_q;
	assign oq_valid  = scanning && ssts.hit;

	always_comb begin
		sctl.load = accept || to_close;
		sctl.step = advance && ssts.more;
		if (accept) begin
			load_mask  = s_tuser ? sample : (sample ^ prev_q);
			load_level = sample;
		end else begin
			load_mask  = sample_q;
			load_level = sample_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_q  <= '0;
			time_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN_A;
						prev_q  <= sample;
						time_q  <= s_tuser ? '0 : time_next;
					end
				end
				ST_SCAN_A: begin
					if (advance && !ssts.more) begin
						state_q <= close_q ? ST_SCAN_B : ST_IDLE;
					end
				end
				ST_SCAN_B: begin
					if (advance && !ssts.more) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q  <= sample;
			use_lev_q <= !s_tuser;
			close_q   <= s_tlast && (|sample);
			etime_q   <= s_tuser ? '0 : time_next;
		end else if (to_close) begin
			etime_q <= time_next;
		end
	end

	bet_scan #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.CHAN_W       (CHAN_W)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (sctl),
		.load_mask  (load_mask),
		.load_level (load_level),
		.sts        (ssts),
		.chan       (chan)
	);

	always_comb begin
		chan_ext       = {{bet_pkg::CHAN_IDX_W{1'b0}}, chan};
		time_ext       = {{bet_pkg::EDGE_TIME_W{1'b0}}, etime_q};
		new_edge.chan  = chan_ext[bet_pkg::CHAN_IDX_W-1:0];
		new_edge.etime = time_ext[bet_pkg::EDGE_TIME_W-1:0];
		if (state_q == ST_SCAN_B) begin
			new_edge.kind = bet_pkg::EDGE_TRAILING;
		end else if (use_lev_q && !ssts.level) begin
			new_edge.kind = bet_pkg::EDGE_TRAILING;
		end else begin
			new_edge.kind = bet_pkg::EDGE_LEADING;
		end
		new_edge.last = !ssts.more && ((state_q == ST_SCAN_B) || !close_q);
	end

	bet_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (oq_valid),
		.in_ready  (oq_ready),
		.in_edge   (new_edge),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_edge  (out_edge)
	);

	assign m_tdata = {3'b000, out_edge.etime, out_edge.chan};
	assign m_tuser = out_edge.kind;
	assign m_tlast = out_edge.last;

endmodule

`default_nettype wire

// ===== rtl/core/bet_checker.sv =====
`default_nettype none

module bet_checker #(
	parameter int unsigned NUM_CHANNELS = 32
) (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata,
	input wire        m_tlast
);

	// A transfer that is held back keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("held output transfer changed");

	// A new slot is never taken right after one was taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while the previous slot is in work");

	// No new slot while the edges of the current one are still coming.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready in the middle of an edge run");

	// Only existing channels are reported, and the padding stays clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[4:0] < NUM_CHANNELS) && (m_tdata[23:21] == 3'b000))
		else $error("bad channel index or padding");

endmodule

bind bitmap_edge_timestamper_unit bet_checker #(
	.NUM_CHANNELS (NUM_CHANNELS)
) u_bet_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/tb_bitmap_edge_timestamper_unit.sv =====
`default_nettype none

module tb_bitmap_edge_timestamper_unit;

	localparam int unsigned CYCLE_LIMIT   = 3000000;
	localparam int unsigned SETTLE_CYCLES = 100;
	localparam int unsigned RANDOM_SLOTS  = 340;
	localparam int unsigned HOLD_SLOTS    = 8;

	class edge_scoreboard;
		logic [bet_pkg::SAMPLE_W-1:0]    prev_levels;
		logic [bet_pkg::EDGE_TIME_W-1:0] slot_time;
		bet_pkg::edge_t                  pending_edges[$];
		int unsigned                     errors;

		function new();
			prev_levels = '0;
			slot_time   = '0;
			errors      = 0;
		endfunction

		function void add_edge(int unsigned chan, logic kind,
				logic [bet_pkg::EDGE_TIME_W-1:0] etime);
			bet_pkg::edge_t e;
			e.chan  = chan[bet_pkg::CHAN_IDX_W-1:0];
			e.kind  = kind;
			e.etime = etime;
			e.last  = 1'b0;
			pending_edges.push_back(e);
		endfunction

		// Works out the edges that one accepted slot produces.
		function void note_slot(logic [bet_pkg::SAMPLE_W-1:0] levels, logic first,
				logic closing);
			logic [bet_pkg::SAMPLE_W-1:0]    changed;
			logic [bet_pkg::EDGE_TIME_W-1:0] close_time;
			int unsigned                     base;
			base = pending_edges.size();
			if (first) begin
				slot_time = '0;
				for (int ch = 0; ch < bet_pkg::SAMPLE_W; ch++)
					if (levels[ch])
						add_edge(ch, bet_pkg::EDGE_LEADING, slot_time);
			end else begin
				changed = levels ^ prev_levels;
				if (slot_time != '1)
					slot_time = slot_time + 1'b1;
				for (int ch = 0; ch < bet_pkg::SAMPLE_W; ch++)
					if (changed[ch])
						add_edge(ch, levels[ch] ? bet_pkg::EDGE_LEADING
							: bet_pkg::EDGE_TRAILING, slot_time);
			end
			if (closing) begin
				close_time = (slot_time == '1) ? slot_time : slot_time + 1'b1;
				for (int ch = 0; ch < bet_pkg::SAMPLE_W; ch++)
					if (levels[ch])
						add_edge(ch, bet_pkg::EDGE_TRAILING, close_time);
			end
			prev_levels = levels;
			if (pending_edges.size() > base)
				pending_edges[pending_edges.size() - 1].last = 1'b1;
		endfunction

		task report_mismatch(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_edge(logic [bet_pkg::CHAN_IDX_W-1:0] chan, logic kind,
				logic [bet_pkg::EDGE_TIME_W-1:0] etime, logic last);
			bet_pkg::edge_t want;
			if (pending_edges.size() == 0) begin
				report_mismatch($sformatf("unexpected edge chan %0d kind %0d time %0d",
					chan, kind, etime));
				return;
			end
			want = pending_edges.pop_front();
			if (chan !== want.chan)
				report_mismatch($sformatf("channel %0d, wanted %0d", chan, want.chan));
			if (kind !== want.kind)
				report_mismatch($sformatf("kind %0d on channel %0d, wanted %0d",
					kind, want.chan, want.kind));
			if (etime !== want.etime)
				report_mismatch($sformatf("time %0d on channel %0d, wanted %0d",
					etime, want.chan, want.etime));
			if (last !== want.last)
				report_mismatch($sformatf("last flag %0d on channel %0d, wanted %0d",
					last, want.chan, want.last));
		endtask
	endclass

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [bet_pkg::SAMPLE_W-1:0]    s_tdata  = '0;
	logic                            s_tuser  = 1'b0;
	logic                            s_tlast  = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [bet_pkg::M_TDATA_W-1:0]   m_tdata;
	logic                            m_tuser;
	logic                            m_tlast;

	edge_scoreboard                  sb;
	logic                            send_idle_on = 1'b1;
	logic                            recv_idle_on = 1'b1;
	logic [bet_pkg::SAMPLE_W-1:0]    last_levels  = '0;
	int unsigned                     slots_sent   = 0;
	int unsigned                     cycle_count  = 0;

	bitmap_edge_timestamper_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= !(recv_idle_on && $urandom_range(0, 99) < 35);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_edge(m_tdata[bet_pkg::CHAN_IDX_W-1:0], m_tuser,
				m_tdata[bet_pkg::CHAN_IDX_W +: bet_pkg::EDGE_TIME_W], m_tlast);
	end

	task automatic send_slot(input logic [bet_pkg::SAMPLE_W-1:0] levels, input logic first,
			input logic closing);
		@(negedge clk);
		while (send_idle_on && $urandom_range(0, 99) < 35) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = levels;
		s_tuser  = first;
		s_tlast  = closing;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_slot(levels, first, closing);
		last_levels = levels;
		slots_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending_edges.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [bet_pkg::SAMPLE_W-1:0] next_levels(
			logic [bet_pkg::SAMPLE_W-1:0] prev);
		logic [bet_pkg::SAMPLE_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = '1;
			2, 3: v = prev ^ (32'h1 << $urandom_range(0, 31));
			4, 5: v = prev ^ (32'h1 << $urandom_range(0, 31)) ^ (32'h1 << $urandom_range(0, 31));
			6: v = prev;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	initial begin
		int unsigned target;
		int unsigned frame_no;
		int unsigned len;
		logic        broken_end;
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Samples before any frame was started count on from the reset time.
		send_slot(32'h0000_0005, 1'b0, 1'b0);
		send_slot(32'hFFFF_FFFF, 1'b1, 1'b0);
		send_slot(32'h0000_0000, 1'b0, 1'b0);
		send_slot(32'h0000_0000, 1'b0, 1'b0);
		send_slot(32'hAAAA_AAAA, 1'b0, 1'b0);
		send_slot(32'h5555_5555, 1'b0, 1'b0);
		send_slot(32'h8000_0001, 1'b0, 1'b0);
		send_slot(32'hFFFF_FFFF, 1'b0, 1'b1);
		send_slot(32'hFFFF_FFFF, 1'b1, 1'b1);
		send_slot(32'h0000_0000, 1'b1, 1'b1);
		send_slot(32'h8000_0000, 1'b1, 1'b0);
		send_slot(32'h0000_0001, 1'b0, 1'b0);
		send_slot(32'h0000_0000, 1'b0, 1'b1);
		send_slot(32'h0001_0000, 1'b0, 1'b0);
		send_slot(32'h0001_8000, 1'b0, 1'b1);
		send_slot(32'h7FFF_FFFE, 1'b1, 1'b1);
		send_slot(32'h0000_0000, 1'b0, 1'b0);
		wait_drained();

		// A frame with a run of unchanged samples, sent back to back.
		send_idle_on = 1'b0;
		send_slot(32'h0000_0001, 1'b1, 1'b0);
		for (int i = 0; i < HOLD_SLOTS; i++)
			send_slot(32'h0000_0001, 1'b0, 1'b0);
		send_slot(32'h0000_0003, 1'b0, 1'b0);
		send_slot(32'h0000_0002, 1'b0, 1'b1);
		send_slot(32'hC000_0000, 1'b0, 1'b0);
		send_slot(32'h4000_0000, 1'b1, 1'b0);
		wait_drained();
		send_idle_on = 1'b1;

		target   = slots_sent + RANDOM_SLOTS;
		frame_no = 0;
		while (slots_sent < target) begin
			send_idle_on = !(frame_no >= 10 && frame_no < 18);
			recv_idle_on = send_idle_on;
			case ($urandom_range(0, 9))
				0: send_slot($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				1: begin
					len        = $urandom_range(1, 6);
					broken_end = 1'($urandom_range(0, 1));
					for (int i = 0; i < len; i++)
						send_slot(next_levels(last_levels), 1'b0,
							broken_end && (i == len - 1));
				end
				default: begin
					len = $urandom_range(1, 12);
					for (int i = 0; i < len; i++)
						send_slot(next_levels(last_levels), i == 0, i == len - 1);
				end
			endcase
			if (frame_no == 25 || frame_no == 50)
				wait_drained();
			frame_no++;
		end

		wait_drained();
		if (sb.errors == 0 && sb.pending_edges.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
